// ----- hw/rtl/tfe_pkg.sv -----
package tfe_pkg;

  localparam int PACKET_BYTES_DEF = 512;
  localparam int DATA_OFFSET_DEF  = 6;
  localparam int QUEUE_DEPTH      = 4;
  localparam int NUM_BANKS        = 8;
  localparam int ADDR_W           = 10;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  localparam logic [3:0] KIND_UB  = 4'd0;
  localparam logic [3:0] KIND_SB  = 4'd1;
  localparam logic [3:0] KIND_IU1 = 4'd2;
  localparam logic [3:0] KIND_IS1 = 4'd3;
  localparam logic [3:0] KIND_UL1 = 4'd4;
  localparam logic [3:0] KIND_IL1 = 4'd5;
  localparam logic [3:0] KIND_SFP = 4'd6;
  localparam logic [3:0] KIND_DFP = 4'd7;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN  = 2'd1;
  localparam logic [1:0] STATUS_BAD_KIND = 2'd2;
  localparam logic [1:0] STATUS_PAST_END = 2'd3;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  typedef struct packed {
    logic              is_load;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [1:0]        wsel;
    logic [5:0]        shift;
    logic [5:0]        nbits;
    logic              is_signed;
    logic [1:0]        status;
  } cmd_t;

endpackage

// ----- hw/rtl/tfe_if.sv -----
interface tfe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [8:0] byte_index;
  logic [7:0] byte_value;
  logic [8:0] field_start_byte;
  logic [4:0] field_start_bit;
  logic [5:0] field_bits;
  logic [3:0] field_kind;

  modport source (
    output valid, req_type, byte_index, byte_value, field_start_byte,
           field_start_bit, field_bits, field_kind,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_index, byte_value, field_start_byte,
           field_start_bit, field_bits, field_kind,
    output ready
  );
endinterface

interface tfe_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        raw_field;
  logic signed [32:0] signed_field;
  logic [1:0]         status;

  modport source (
    output valid, raw_field, signed_field, status,
    input  ready
  );
  modport sink (
    input  valid, raw_field, signed_field, status,
    output ready
  );
endinterface

// ----- hw/rtl/tfe_front.sv -----
module tfe_front #(
  parameter int PACKET_BYTES = tfe_pkg::PACKET_BYTES_DEF,
  parameter int DATA_OFFSET  = tfe_pkg::DATA_OFFSET_DEF
) (
  tfe_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output tfe_pkg::cmd_t   cmd
);

  localparam int CMP_RAW = $clog2(PACKET_BYTES + 1);
  localparam int CMP_W   = (CMP_RAW > 11) ? CMP_RAW : 11;
  localparam logic [CMP_W-1:0] PB_L = CMP_W'(PACKET_BYTES);

  logic [1:0]                  wsel;
  logic [6:0]                  width_bits;
  logic [3:0]                  nbytes;
  logic                        known;
  logic [tfe_pkg::ADDR_W-1:0]  addr;
  logic [CMP_W-1:0]            end_byte;
  logic [6:0]                  bit_end;
  logic [1:0]                  status;
  logic                        load_ok;
  logic                        is_load;

  always_comb begin
    wsel       = tfe_pkg::WSEL_8;
    width_bits = 7'd8;
    nbytes     = 4'd1;
    known      = 1'b1;
    unique case (in_ch.field_kind) inside
      tfe_pkg::KIND_UB, tfe_pkg::KIND_SB: begin
        wsel       = tfe_pkg::WSEL_8;
        width_bits = 7'd8;
        nbytes     = 4'd1;
      end
      tfe_pkg::KIND_IU1, tfe_pkg::KIND_IS1: begin
        wsel       = tfe_pkg::WSEL_16;
        width_bits = 7'd16;
        nbytes     = 4'd2;
      end
      tfe_pkg::KIND_UL1, tfe_pkg::KIND_IL1, tfe_pkg::KIND_SFP: begin
        wsel       = tfe_pkg::WSEL_32;
        width_bits = 7'd32;
        nbytes     = 4'd4;
      end
      tfe_pkg::KIND_DFP: begin
        wsel       = tfe_pkg::WSEL_64;
        width_bits = 7'd64;
        nbytes     = 4'd8;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign addr     = tfe_pkg::ADDR_W'(DATA_OFFSET)
                  + {1'b0, in_ch.field_start_byte};
  assign end_byte = CMP_W'(addr) + CMP_W'(nbytes);
  assign bit_end  = 7'(in_ch.field_start_bit) + 7'(in_ch.field_bits);

  always_comb begin
    if (!known) begin
      status = tfe_pkg::STATUS_BAD_KIND;
    end else if (end_byte > PB_L) begin
      status = tfe_pkg::STATUS_PAST_END;
    end else if (wsel == tfe_pkg::WSEL_64) begin
      status = tfe_pkg::STATUS_OK;
    end else if (bit_end > width_bits) begin
      status = tfe_pkg::STATUS_OVERRUN;
    end else begin
      status = tfe_pkg::STATUS_OK;
    end
  end

  assign is_load = (in_ch.req_type == tfe_pkg::REQ_LOAD);
  assign load_ok = (CMP_W'(in_ch.byte_index) < PB_L);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full && (!is_load || load_ok);

  always_comb begin
    cmd.is_load   = is_load;
    cmd.addr      = is_load ? {1'b0, in_ch.byte_index} : addr;
    cmd.data      = in_ch.byte_value;
    cmd.wsel      = wsel;
    cmd.shift     = 6'(width_bits - bit_end);
    cmd.nbits     = in_ch.field_bits;
    cmd.is_signed = (in_ch.field_kind == tfe_pkg::KIND_SB)
                 || (in_ch.field_kind == tfe_pkg::KIND_IS1)
                 || (in_ch.field_kind == tfe_pkg::KIND_IL1);
    cmd.status    = status;
  end

endmodule

// ----- hw/rtl/tfe_queue.sv -----
module tfe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tfe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tfe_pkg::cmd_t head_cmd
);

  localparam int DEPTH = tfe_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  tfe_pkg::cmd_t   slot_r [DEPTH];
  logic [PW-1:0]   head_r, tail_r;
  logic [PW-1:0]   head_nxt, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[head_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[tail_r] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/tfe_back.sv -----
module tfe_back #(
  parameter int PACKET_BYTES = tfe_pkg::PACKET_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  tfe_pkg::cmd_t head_cmd,
  output logic          pop,
  tfe_out_if.source     out_ch
);

  localparam int NB          = tfe_pkg::NUM_BANKS;
  localparam int REACH       = 1 << tfe_pkg::ADDR_W;
  localparam int STORE_BYTES = (PACKET_BYTES < REACH) ? PACKET_BYTES : REACH;
  localparam int ROWS        = (STORE_BYTES + NB - 1) / NB;
  localparam int RW          = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW          = $clog2(NB);

  logic [RW-1:0]  base_row;
  logic [LW-1:0]  head_lo;
  logic           wr_en, rd_en;
  logic [7:0]     rd_byte [NB];

  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_adv;
  logic [1:0]     s1_wsel_r;
  logic [5:0]     s1_shift_r;
  logic [5:0]     s1_nbits_r;
  logic           s1_signed_r;
  logic [1:0]     s1_status_r;
  logic [LW-1:0]  s1_lo_r;

  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_raw_r, raw_nxt;
  logic signed [32:0] out_sgn_r, sgn_nxt;
  logic [1:0]         out_status_r;

  logic [63:0]    word;
  logic [31:0]    cont;
  logic [31:0]    shifted;
  logic [32:0]    mask;
  logic [31:0]    field;

  assign base_row = RW'(head_cmd.addr[tfe_pkg::ADDR_W-1:LW]);
  assign head_lo  = head_cmd.addr[LW-1:0];

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign pop    = head_valid && (!s1_valid_r || s1_adv);
  assign wr_en  = pop && head_cmd.is_load;
  assign rd_en  = pop && !head_cmd.is_load;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    localparam logic [LW-1:0] BANK = LW'(b);
    logic [7:0]    mem_r [ROWS];
    logic [7:0]    rd_r;
    logic [RW-1:0] row;

    assign row        = base_row + RW'(BANK < head_lo);
    assign rd_byte[b] = rd_r;

    always_ff @(posedge clk) begin
      if (wr_en && head_lo == BANK) begin
        mem_r[base_row] <= head_cmd.data;
      end
      if (rd_en) begin
        rd_r <= mem_r[row];
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_wsel_r   <= head_cmd.wsel;
      s1_shift_r  <= head_cmd.shift;
      s1_nbits_r  <= head_cmd.nbits;
      s1_signed_r <= head_cmd.is_signed;
      s1_status_r <= head_cmd.status;
      s1_lo_r     <= head_lo;
    end
    if (s1_adv) begin
      out_raw_r    <= raw_nxt;
      out_sgn_r    <= sgn_nxt;
      out_status_r <= s1_status_r;
    end
  end

  // big-endian word starting at the field's first byte
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      word[63 - 8 * i -: 8] = rd_byte[LW'(s1_lo_r + LW'(i))];
    end
  end

  always_comb begin
    unique case (s1_wsel_r)
      tfe_pkg::WSEL_8:  cont = {24'd0, word[63:56]};
      tfe_pkg::WSEL_16: cont = {16'd0, word[63:48]};
      default:          cont = word[63:32];
    endcase
    shifted = cont >> s1_shift_r;
    mask    = (33'd1 << s1_nbits_r) - 33'd1;
    field   = shifted & mask[31:0];
  end

  always_comb begin
    raw_nxt = 64'd0;
    sgn_nxt = 33'sd0;
    if (s1_status_r == tfe_pkg::STATUS_OK) begin
      if (s1_wsel_r == tfe_pkg::WSEL_64) begin
        raw_nxt = word;
        sgn_nxt = word[32:0];
      end else begin
        raw_nxt = {32'd0, field};
        sgn_nxt = {1'b0, field};
        if (s1_signed_r) begin
          unique case (s1_wsel_r)
            tfe_pkg::WSEL_8:  sgn_nxt = {{25{field[7]}}, field[7:0]};
            tfe_pkg::WSEL_16: sgn_nxt = {{17{field[15]}}, field[15:0]};
            default:          sgn_nxt = {field[31], field};
          endcase
        end
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.raw_field    = out_raw_r;
  assign out_ch.signed_field = out_sgn_r;
  assign out_ch.status       = out_status_r;

endmodule

// ----- hw/rtl/telemetry_field_extractor.sv -----
// extract path: queue, then bank read and stage-one registers, then output registers
// throughput: one request per cycle, loads and extracts alike, while out_ch is not back-pressured;
//   the store is eight byte banks, so one bank read per cycle fetches all eight bytes of any container
// loads cause no result; loads past the store are dropped
// reset: synchronous active-low rst_n empties the queue and the pipeline; store contents
//   stay undefined until written, and no clearing pass is made
module telemetry_field_extractor #(
  parameter int PACKET_BYTES = tfe_pkg::PACKET_BYTES_DEF,
  parameter int DATA_OFFSET  = tfe_pkg::DATA_OFFSET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tfe_in_if.sink     in_ch,
  tfe_out_if.source  out_ch
);

  logic          push;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  tfe_pkg::cmd_t push_cmd;
  tfe_pkg::cmd_t head_cmd;

  tfe_front #(
    .PACKET_BYTES (PACKET_BYTES),
    .DATA_OFFSET  (DATA_OFFSET)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  tfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tfe_back #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
